[hdl/swrr_pkg.sv]
// ----------------------------------------------------------------------------
// swrr_pkg
// Shared types, codes and defaults for the smooth weighted round-robin unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swrr_pkg;

	localparam int ENTRIES_DEFAULT     = 16;
	localparam int WEIGHT_BITS_DEFAULT = 8;

	localparam int ACTIVE_W = 5;
	localparam int RW_W     = 16;

	localparam logic signed [RW_W-1:0] RW_MAX = 16'sh7fff;
	localparam logic signed [RW_W-1:0] RW_MIN = 16'sh8000;

	localparam logic [1:0] OP_SELECT = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_HEALTH = 2'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NO_ACTIVE   = 2'd1;
	localparam logic [1:0] ST_NO_ELIGIBLE = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] entry_index;
		logic [7:0] entry_weight;
		logic       healthy_flag;
	} req_t;

	typedef struct packed {
		logic [3:0] selected_index;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic walk_start;
		logic rd_en;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_select;
		logic n_zero;
		logic last_issue;
	} stat_t;

endpackage

`default_nettype wire

[hdl/swrr_ctrl.sv]
// ----------------------------------------------------------------------------
// swrr_ctrl
// Sequencer for request capture, table walk, winner update and response.
// ----------------------------------------------------------------------------
`default_nettype none

module swrr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	input  wire swrr_pkg::stat_t stat,
	output swrr_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.capture    = req_valid && (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_select && !stat.n_zero) begin
					cmd.walk_start = 1'b1;
					state_d        = S_WALK;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_EMIT;
				end
			end
			S_WALK: begin
				cmd.rd_en = 1'b1;
				if (stat.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINAL;
			end
			S_FINAL: begin
				cmd.finish = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/swrr_datapath.sv]
// ----------------------------------------------------------------------------
// swrr_datapath
// Entry tables, walk counter, accumulate and compare unit, response register.
// ----------------------------------------------------------------------------
`default_nettype none

module swrr_datapath #(
	parameter int ENTRIES     = swrr_pkg::ENTRIES_DEFAULT,
	parameter int WEIGHT_BITS = swrr_pkg::WEIGHT_BITS_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire swrr_pkg::req_t                 req_data,
	output swrr_pkg::rsp_t                      rsp_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [swrr_pkg::ACTIVE_W-1:0]  cfg_data,
	input  wire swrr_pkg::cmd_t                 cmd,
	output swrr_pkg::stat_t                     stat
);

	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = IDX_W + 1;
	localparam int RW_W    = swrr_pkg::RW_W;
	localparam int SUM_W   = RW_W + 2;
	localparam int TOTAL_W = WEIGHT_BITS + IDX_W;
	localparam int DIFF_W  = ((TOTAL_W > RW_W) ? TOTAL_W : RW_W) + 2;

	swrr_pkg::req_t                 item_q;
	swrr_pkg::rsp_t                 res_q;
	swrr_pkg::rsp_t                 rsp_q;
	logic [swrr_pkg::ACTIVE_W-1:0]  active_q;

	logic [WEIGHT_BITS-1:0]         wt_mem [ENTRIES];
	logic signed [RW_W-1:0]         rw_mem [ENTRIES];
	logic [ENTRIES-1:0]             ent_vld_q;
	logic [ENTRIES-1:0]             health_q;

	logic [WEIGHT_BITS-1:0]         wt_rd_s1;
	logic signed [RW_W-1:0]         rw_rd_s1;
	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               k_s1;

	logic [IDX_W-1:0]               cnt_q;
	logic [TOTAL_W-1:0]             total_q;
	logic signed [RW_W-1:0]         best_q;
	logic [IDX_W-1:0]               win_q;
	logic                           found_q;

	logic                           in_range;
	logic [IDX_W-1:0]               ld_addr;
	logic [WEIGHT_BITS-1:0]         ld_weight;
	logic                           load_we;
	logic                           health_we;
	logic [CNT_W-1:0]               eff_n;

	logic [WEIGHT_BITS-1:0]         w_eff;
	logic signed [RW_W-1:0]         rw_eff;
	logic signed [SUM_W-1:0]        add_sum;
	logic signed [RW_W-1:0]         upd_rw;
	logic                           proc_hit;
	logic                           walk_we;

	logic signed [DIFF_W-1:0]       diff;
	logic signed [RW_W-1:0]         fin_rw;
	logic                           fin_we;

	logic                           rw_we;
	logic [IDX_W-1:0]               rw_wa;
	logic signed [RW_W-1:0]         rw_wd;

	assign cfg_ready = 1'b1;
	assign rsp_data  = rsp_q;

	assign in_range  = 32'(item_q.entry_index) < ENTRIES;
	assign ld_addr   = IDX_W'(item_q.entry_index);
	assign ld_weight = WEIGHT_BITS'(item_q.entry_weight);
	assign load_we   = cmd.exec && in_range && (item_q.operation == swrr_pkg::OP_LOAD);
	assign health_we = cmd.exec && in_range &&
		((item_q.operation == swrr_pkg::OP_LOAD) ||
		 (item_q.operation == swrr_pkg::OP_HEALTH));

	assign eff_n = (32'(active_q) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(active_q);

	assign stat.is_select  = (item_q.operation == swrr_pkg::OP_SELECT);
	assign stat.n_zero     = (active_q == '0);
	assign stat.last_issue = ((CNT_W'(cnt_q) + CNT_W'(1)) == eff_n);

	// accumulate and compare for the entry whose read data just arrived
	assign w_eff    = ent_vld_q[k_s1] ? wt_rd_s1 : '0;
	assign rw_eff   = ent_vld_q[k_s1] ? rw_rd_s1 : '0;
	assign add_sum  = SUM_W'(rw_eff) + SUM_W'(w_eff);
	assign proc_hit = rd_vld_s1 && health_q[k_s1];
	assign walk_we  = proc_hit && ent_vld_q[k_s1];

	always_comb begin
		if ((add_sum[SUM_W-1:RW_W-1] == '0) || (add_sum[SUM_W-1:RW_W-1] == '1)) begin
			upd_rw = add_sum[RW_W-1:0];
		end else begin
			upd_rw = add_sum[SUM_W-1] ? swrr_pkg::RW_MIN : swrr_pkg::RW_MAX;
		end
	end

	// winner takes off the healthy weight sum
	assign diff   = DIFF_W'(best_q) - DIFF_W'(total_q);
	assign fin_we = cmd.finish && found_q;

	always_comb begin
		if ((diff[DIFF_W-1:RW_W-1] == '0) || (diff[DIFF_W-1:RW_W-1] == '1)) begin
			fin_rw = diff[RW_W-1:0];
		end else begin
			fin_rw = diff[DIFF_W-1] ? swrr_pkg::RW_MIN : swrr_pkg::RW_MAX;
		end
	end

	always_comb begin
		rw_we = 1'b0;
		rw_wa = ld_addr;
		rw_wd = '0;
		if (load_we) begin
			rw_we = 1'b1;
		end else if (walk_we) begin
			rw_we = 1'b1;
			rw_wa = k_s1;
			rw_wd = upd_rw;
		end else if (fin_we) begin
			rw_we = 1'b1;
			rw_wa = win_q;
			rw_wd = fin_rw;
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			wt_mem[ld_addr] <= ld_weight;
		end
		if (cmd.rd_en) begin
			wt_rd_s1 <= wt_mem[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rw_we) begin
			rw_mem[rw_wa] <= rw_wd;
		end
		if (cmd.rd_en) begin
			rw_rd_s1 <= rw_mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			health_q  <= '0;
			active_q  <= '0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
			total_q   <= '0;
			best_q    <= '0;
			win_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				active_q <= cfg_data;
			end
			if (load_we) begin
				ent_vld_q[ld_addr] <= 1'b1;
			end
			if (health_we) begin
				health_q[ld_addr] <= item_q.healthy_flag;
			end
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.walk_start) begin
				cnt_q   <= '0;
				total_q <= '0;
				best_q  <= '0;
				win_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
				if (proc_hit) begin
					total_q <= total_q + TOTAL_W'(w_eff);
					if (upd_rw > best_q) begin
						best_q  <= upd_rw;
						win_q   <= k_s1;
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req_data;
		end
		if (cmd.rd_en) begin
			k_s1 <= cnt_q;
		end
		if (cmd.exec) begin
			if (item_q.operation == swrr_pkg::OP_SELECT) begin
				res_q.selected_index <= '0;
				res_q.status         <= swrr_pkg::ST_NO_ACTIVE;
			end else begin
				res_q.selected_index <= item_q.entry_index;
				res_q.status         <= swrr_pkg::ST_OK;
			end
		end else if (cmd.finish) begin
			res_q.selected_index <= found_q ? 4'(win_q) : 4'd0;
			res_q.status         <= found_q ? swrr_pkg::ST_OK : swrr_pkg::ST_NO_ELIGIBLE;
		end
		if (cmd.emit) begin
			rsp_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_found_positive: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_q > 0))
		else $error("winner recorded without a positive running weight");

	a_finish_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !rd_vld_s1 && !cmd.rd_en)
		else $error("finish while walk data still in flight");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (CNT_W'(cnt_q) < eff_n))
		else $error("walk read beyond active entries");

	a_walk_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en && stat.last_issue |=> !cmd.rd_en)
		else $error("walk continued past last entry");
`endif

endmodule

`default_nettype wire

[hdl/smooth_weighted_round_robin_unit.sv]
// ----------------------------------------------------------------------------
// smooth_weighted_round_robin_unit
// Weighted round-robin selector with load, health and select requests.
// ----------------------------------------------------------------------------
// load, health, unused requests and selects with no active entries: the request runs
//   through EXEC to EMIT; a new request is taken only once back in IDLE after EMIT
// other selects: EXEC, a table walk over n entries, DRAIN, FINAL, then EMIT, where
//   n = active entries capped at ENTRIES; the table walk reads one entry a cycle
// reset: tables read as zero through per-entry valid bits, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_weighted_round_robin_unit #(
	parameter int ENTRIES     = swrr_pkg::ENTRIES_DEFAULT,
	parameter int WEIGHT_BITS = swrr_pkg::WEIGHT_BITS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire swrr_pkg::req_t                req_data,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output swrr_pkg::rsp_t                     rsp_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [swrr_pkg::ACTIVE_W-1:0] cfg_data
);

	swrr_pkg::cmd_t  cmd;
	swrr_pkg::stat_t stat;

	swrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	swrr_datapath #(
		.ENTRIES     (ENTRIES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire
